>>> design/assert_macros.svh
// Assertion macros used by the indexed deque list RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define DQL_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
`define DQL_NEVER(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);
`else
`define DQL_ASSERT(label, prop, msg)
`define DQL_NEVER(label, cond, msg)
`endif
`endif

>>> design/dql_pkg.sv
// Types, constants and helper functions of the indexed deque list.
package dql_pkg;

	localparam int CAPACITY    = 16;
	localparam int VALUE_WIDTH = 32;

	localparam int CNT_W = $clog2(CAPACITY + 1);
	localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

	// Fixed field widths of the stream channels.
	localparam int CMD_FW   = 3;
	localparam int POS_FW   = 5;
	localparam int DATA_FW  = 32;
	localparam int STAT_FW  = 2;
	localparam int COUNT_FW = 5;

	localparam int CMP_W = (POS_FW > CNT_W) ? POS_FW : CNT_W;

	localparam int IN_BITS      = POS_FW + DATA_FW;
	localparam int IN_TDATA_W   = ((IN_BITS + 7) / 8) * 8;
	localparam int IN_PAD_W     = IN_TDATA_W - IN_BITS;
	localparam int IN_TUSER_W   = CMD_FW;
	localparam int OUT_BITS     = 3 * DATA_FW + COUNT_FW;
	localparam int OUT_TDATA_W  = ((OUT_BITS + 7) / 8) * 8;
	localparam int OUT_PAD_W    = OUT_TDATA_W - OUT_BITS;
	localparam int OUT_TUSER_W  = 1 + STAT_FW;

	typedef logic [VALUE_WIDTH-1:0] val_t;
	typedef logic [CNT_W-1:0]       cnt_t;
	typedef logic [IDX_W-1:0]       idx_t;
	typedef logic [DATA_FW-1:0]     data_t;

	typedef enum logic [CMD_FW-1:0] {
		OP_PUSH_FRONT = 3'd0,
		OP_PUSH_BACK  = 3'd1,
		OP_POP_FRONT  = 3'd2,
		OP_POP_BACK   = 3'd3,
		OP_GET        = 3'd4,
		OP_REMOVE     = 3'd5,
		OP_INSERT     = 3'd6,
		OP_CLEAR      = 3'd7
	} op_t;

	typedef enum logic [STAT_FW-1:0] {
		ST_OK    = 2'd0,
		ST_RANGE = 2'd1,
		ST_FULL  = 2'd2
	} st_t;

	typedef struct packed {
		op_t                op;
		logic [POS_FW-1:0]  pos;
		data_t              value;
	} cmd_t;

	typedef struct packed {
		data_t               out_value;
		logic                out_valid;
		st_t                 status;
		logic [COUNT_FW-1:0] count;
		data_t               front;
		data_t               back;
	} res_t;

	typedef struct packed {
		logic we;
		idx_t waddr;
		val_t wdata;
		logic re;
		idx_t raddr;
	} mem_req_t;

	function automatic data_t val_to_port(val_t v);
		logic [VALUE_WIDTH+DATA_FW-1:0] w;
		w = '0;
		w[VALUE_WIDTH-1:0] = v;
		return w[DATA_FW-1:0];
	endfunction

	function automatic val_t port_to_val(data_t d);
		logic [VALUE_WIDTH+DATA_FW-1:0] w;
		w = '0;
		w[DATA_FW-1:0] = d;
		return w[VALUE_WIDTH-1:0];
	endfunction

	function automatic logic [COUNT_FW-1:0] cnt_to_port(cnt_t c);
		logic [CNT_W+COUNT_FW-1:0] w;
		w = '0;
		w[CNT_W-1:0] = c;
		return w[COUNT_FW-1:0];
	endfunction

endpackage

>>> design/dql_ram.sv
// Simple dual-port RAM: one write port, one read port with registered data.
module dql_ram #(
	parameter int DEPTH = 16,
	parameter int WIDTH = 32
) (
	input  logic                                   clk,
	input  logic                                   we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                       wdata,
	input  logic                                   re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                       rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

>>> design/dql_seq.sv
// Command sequencer: decodes a command and walks the entry RAM one slot a cycle.
`include "assert_macros.svh"

module dql_seq (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cmd_valid,
	input  dql_pkg::cmd_t     cmd,
	output logic              idle,
	output logic              res_valid,
	output dql_pkg::res_t     res,
	input  logic              res_ready,
	output dql_pkg::mem_req_t mem_req,
	input  dql_pkg::val_t     rdata
);
	import dql_pkg::*;

	typedef enum logic [2:0] {
		S_IDLE,
		S_SHIFT,
		S_PUT,
		S_RDF,
		S_RDB,
		S_WB,
		S_DONE
	} state_t;

	state_t state_q;
	cnt_t   count_q;
	cnt_t   n_q;
	idx_t   ptr_q;
	idx_t   idx_q;
	idx_t   tgt_q;
	logic   up_q;
	logic   first_q;
	logic   pend_q;
	logic   cap_q;
	val_t   val_q;
	st_t    status_q;
	val_t   out_val_q;
	logic   out_valid_q;
	val_t   front_q;
	val_t   back_q;

	// Decode of the command against the current count.
	state_t           d_state;
	st_t              d_status;
	logic             d_up;
	idx_t             d_idx;
	idx_t             d_ptr;
	cnt_t             d_n;
	cnt_t             d_count;
	logic [CMP_W-1:0] pos_c;
	logic [CMP_W-1:0] cnt_c;
	cnt_t             cnt_dec;
	logic             full;
	logic             empty;

	assign pos_c   = CMP_W'(cmd.pos);
	assign cnt_c   = CMP_W'(count_q);
	assign cnt_dec = count_q - CNT_W'(1);
	assign full    = (count_q == CNT_W'(CAPACITY));
	assign empty   = (count_q == '0);

	always_comb begin
		d_state  = S_RDF;
		d_status = ST_OK;
		d_up     = 1'b0;
		d_idx    = '0;
		d_ptr    = '0;
		d_n      = '0;
		d_count  = count_q;
		unique case (cmd.op) inside
			OP_PUSH_FRONT, OP_PUSH_BACK: begin
				if (full) begin
					d_status = ST_FULL;
				end else begin
					d_up    = 1'b1;
					d_idx   = (cmd.op == OP_PUSH_FRONT) ? '0 : count_q[IDX_W-1:0];
					d_ptr   = cnt_dec[IDX_W-1:0];
					d_n     = count_q - CNT_W'(d_idx);
					d_count = count_q + CNT_W'(1);
					d_state = S_SHIFT;
				end
			end
			OP_POP_FRONT, OP_POP_BACK: begin
				if (empty) begin
					d_status = ST_RANGE;
				end else begin
					d_idx   = (cmd.op == OP_POP_FRONT) ? '0 : cnt_dec[IDX_W-1:0];
					d_ptr   = d_idx;
					d_n     = count_q - CNT_W'(d_idx);
					d_count = cnt_dec;
					d_state = S_SHIFT;
				end
			end
			OP_GET: begin
				if (pos_c >= cnt_c) begin
					d_status = ST_RANGE;
				end else begin
					d_idx   = pos_c[IDX_W-1:0];
					d_ptr   = d_idx;
					d_n     = CNT_W'(1);
					d_state = S_SHIFT;
				end
			end
			OP_REMOVE: begin
				if (pos_c >= cnt_c) begin
					d_status = ST_RANGE;
				end else begin
					d_idx   = pos_c[IDX_W-1:0];
					d_ptr   = d_idx;
					d_n     = count_q - CNT_W'(d_idx);
					d_count = cnt_dec;
					d_state = S_SHIFT;
				end
			end
			OP_INSERT: begin
				if (pos_c > cnt_c) begin
					d_status = ST_RANGE;
				end else if (full) begin
					d_status = ST_FULL;
				end else begin
					d_up    = 1'b1;
					d_idx   = pos_c[IDX_W-1:0];
					d_ptr   = cnt_dec[IDX_W-1:0];
					d_n     = count_q - CNT_W'(d_idx);
					d_count = count_q + CNT_W'(1);
					d_state = S_SHIFT;
				end
			end
			OP_CLEAR: begin
				d_count = '0;
			end
			default: begin
				d_count = count_q;
			end
		endcase
	end

	// RAM port. While shifting, the read of one slot overlaps the write of the value read in the
	// cycle before into its neighbour slot; the two addresses always differ by two.
	always_comb begin
		mem_req = '0;
		unique case (state_q)
			S_SHIFT: begin
				if (n_q != '0) begin
					mem_req.re    = 1'b1;
					mem_req.raddr = ptr_q;
				end
				if (pend_q && !cap_q) begin
					mem_req.we    = 1'b1;
					mem_req.waddr = tgt_q;
					mem_req.wdata = rdata;
				end
			end
			S_PUT: begin
				mem_req.we    = 1'b1;
				mem_req.waddr = idx_q;
				mem_req.wdata = val_q;
			end
			S_RDF: begin
				if (count_q != '0) begin
					mem_req.re    = 1'b1;
					mem_req.raddr = '0;
				end
			end
			S_RDB: begin
				mem_req.re    = 1'b1;
				mem_req.raddr = cnt_dec[IDX_W-1:0];
			end
			default: begin
				mem_req = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			n_q         <= '0;
			ptr_q       <= '0;
			idx_q       <= '0;
			tgt_q       <= '0;
			up_q        <= 1'b0;
			first_q     <= 1'b0;
			pend_q      <= 1'b0;
			cap_q       <= 1'b0;
			val_q       <= '0;
			status_q    <= ST_OK;
			out_val_q   <= '0;
			out_valid_q <= 1'b0;
			front_q     <= '0;
			back_q      <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (cmd_valid) begin
						state_q     <= d_state;
						status_q    <= d_status;
						up_q        <= d_up;
						idx_q       <= d_idx;
						ptr_q       <= d_ptr;
						n_q         <= d_n;
						count_q     <= d_count;
						val_q       <= port_to_val(cmd.value);
						out_val_q   <= '0;
						out_valid_q <= 1'b0;
						first_q     <= 1'b1;
						pend_q      <= 1'b0;
						cap_q       <= 1'b0;
					end
				end
				S_SHIFT: begin
					if (n_q != '0) begin
						// On a removal or read the first slot read is the one taken out.
						pend_q  <= 1'b1;
						cap_q   <= first_q && !up_q;
						first_q <= 1'b0;
						tgt_q   <= up_q ? ptr_q + IDX_W'(1) : ptr_q - IDX_W'(1);
						ptr_q   <= up_q ? ptr_q - IDX_W'(1) : ptr_q + IDX_W'(1);
						n_q     <= n_q - CNT_W'(1);
					end else begin
						pend_q <= 1'b0;
					end
					if (pend_q && cap_q) begin
						out_val_q   <= rdata;
						out_valid_q <= 1'b1;
					end
					if (n_q == '0 && !pend_q) begin
						state_q <= up_q ? S_PUT : S_RDF;
					end
				end
				S_PUT: begin
					state_q <= S_RDF;
				end
				S_RDF: begin
					if (count_q == '0) begin
						front_q <= '0;
						back_q  <= '0;
						state_q <= S_DONE;
					end else begin
						state_q <= S_RDB;
					end
				end
				S_RDB: begin
					front_q <= rdata;
					state_q <= S_WB;
				end
				S_WB: begin
					back_q  <= rdata;
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (res_ready) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign idle      = (state_q == S_IDLE);
	assign res_valid = (state_q == S_DONE);

	always_comb begin
		res.out_value = val_to_port(out_val_q);
		res.out_valid = out_valid_q;
		res.status    = status_q;
		res.count     = cnt_to_port(count_q);
		res.front     = val_to_port(front_q);
		res.back      = val_to_port(back_q);
	end

	`DQL_NEVER(a_rw_same_slot, mem_req.we && mem_req.re && (mem_req.waddr == mem_req.raddr), "read and write hit the same slot")
	`DQL_ASSERT(a_value_only_ok, (res_valid && res.out_valid) |-> (res.status == ST_OK), "value returned with error status")
	`DQL_ASSERT(a_full_count, (res_valid && (res.status == ST_FULL)) |-> (count_q == CNT_W'(CAPACITY)), "full status below capacity")
	`DQL_ASSERT(a_count_step, (idle && cmd_valid) |=> ((count_q == $past(count_q) + CNT_W'(1)) || (count_q == $past(count_q)) || (count_q == $past(count_q) - CNT_W'(1)) || (count_q == '0)), "count moved by more than one")

endmodule

>>> design/indexed_deque_list.sv
// Top level of the indexed deque list: stream ports, sequencer and entry RAM.
//
// A command item enters on the s_ group: s_tuser carries the command code, s_tdata the
// position and the new value. Each command gives exactly one result item on the m_ group:
// the value taken or read with its valid flag and status, the entry count after the command
// and the front and back values.
// One item is worked on at a time; s_tready is high only while the sequencer is idle.
// A refused command or a clear goes straight to reading the front and back entries. A push or
// insert first moves the entries from its position onward up a slot, then writes the new value;
// a pop or remove reads from its position onward, returns the first slot read and moves each
// later entry down a slot, and a get reads its one slot. The front and back reads are skipped
// when the list is empty afterward. The longest commands touch every entry: a pop or remove at
// the front of a full list, or a push or insert at the front of a list one short of full.
// The sequencer can take the next item in the cycle after its result is registered.
// The result waits in an output register, so the sequencer is back in idle and takes the
// next item while an earlier result is still held by a stalled receiver; it only waits
// when a second result is finished before the first was taken.
// Reset empties the list at once; no clearing pass runs and stored values stay undefined
// until written, which no command ever reads.
module indexed_deque_list (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_tvalid,
	output logic                                s_tready,
	input  logic [dql_pkg::IN_TDATA_W-1:0]      s_tdata,  // position, new_value, zero pad
	input  logic [dql_pkg::IN_TUSER_W-1:0]      s_tuser,  // cmd
	output logic                                m_tvalid,
	input  logic                                m_tready,
	output logic [dql_pkg::OUT_TDATA_W-1:0]     m_tdata,  // out_value, entry_count, front_value, back_value, zero pad
	output logic [dql_pkg::OUT_TUSER_W-1:0]     m_tuser   // out_valid, status
);
	import dql_pkg::*;

	cmd_t     cmd;
	logic     seq_idle;
	logic     res_valid;
	logic     res_ready;
	res_t     res;
	mem_req_t mem_req;
	val_t     rdata;

	logic                   m_tvalid_q;
	logic [OUT_TDATA_W-1:0] m_tdata_q;
	logic [OUT_TUSER_W-1:0] m_tuser_q;

	assign cmd.op    = op_t'(s_tuser[CMD_FW-1:0]);
	assign cmd.pos   = s_tdata[POS_FW-1:0];
	assign cmd.value = s_tdata[POS_FW+DATA_FW-1:POS_FW];

	assign s_tready  = seq_idle;
	assign res_ready = !m_tvalid_q || m_tready;

	dql_seq u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (s_tvalid),
		.cmd       (cmd),
		.idle      (seq_idle),
		.res_valid (res_valid),
		.res       (res),
		.res_ready (res_ready),
		.mem_req   (mem_req),
		.rdata     (rdata)
	);

	dql_ram #(
		.DEPTH (CAPACITY),
		.WIDTH (VALUE_WIDTH)
	) u_ram (
		.clk   (clk),
		.we    (mem_req.we),
		.waddr (mem_req.waddr),
		.wdata (mem_req.wdata),
		.re    (mem_req.re),
		.raddr (mem_req.raddr),
		.rdata (rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
			m_tdata_q  <= '0;
			m_tuser_q  <= '0;
		end else begin
			if (res_valid && res_ready) begin
				m_tvalid_q <= 1'b1;
				m_tdata_q  <= {{OUT_PAD_W{1'b0}}, res.back, res.front, res.count,
					res.out_value};
				m_tuser_q  <= {res.status, res.out_valid};
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;

endmodule
